// File: rtl/gmb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the greedy meshlet builder.
// No dependencies; every other file imports it.
package gmb_pkg;

	localparam int CNT_W    = 9;   // counts and limits
	localparam int TAG_W    = 32;  // global vertex index
	localparam int CRD_W    = 32;  // Q16.16 coordinate
	localparam int SUM_W    = 40;  // per-axis coordinate sum
	localparam int SQ_W     = 66;  // squared distance, three axes summed
	localparam int ROOT_W   = 33;  // radius
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_LIMIT = 2'd1;

	localparam logic [CNT_W-1:0] VL_RESET  = 9'd64;
	localparam logic [CNT_W-1:0] TL_RESET  = 9'd124;
	localparam logic [CNT_W-1:0] VL_FLOOR  = 9'd3;
	localparam logic [CNT_W-1:0] TL_FLOOR  = 9'd1;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_TRI    = 2'd1;
	localparam logic [1:0] KIND_DESC   = 2'd2;

	typedef struct packed {
		logic [TAG_W-1:0]        tag;
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
	} corner_t;

	// One unit of work for the back end: a full triangle and/or a flush.
	typedef struct packed {
		corner_t [2:0] corner;
		logic          has_tri;
		logic          is_end;
	} job_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [31:0]              word_a;
		logic [31:0]              word_b;
		logic [CNT_W-1:0]         word_c;
		logic [CNT_W-1:0]         tri_total;
		logic signed [CRD_W-1:0]  cx;
		logic signed [CRD_W-1:0]  cy;
		logic signed [CRD_W-1:0]  cz;
		logic [ROOT_W-1:0]        radius;
		logic                     last;
	} rec_t;

endpackage

// File: rtl/gmb_front.sv
`timescale 1ns / 1ps
// Front end: gathers corners into triangles and classifies flush requests.
// Depends on gmb_pkg.
module gmb_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           vertex_index,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic                  end_of_mesh,
	input  logic                  q_full,
	output logic                  q_push,
	output gmb_pkg::job_t         q_job
);
	import gmb_pkg::*;

	logic [1:0] held_q;
	corner_t    hold_q [2];
	corner_t    cur;
	logic       acc;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign cur      = '{tag: vertex_index, x: pos_x, y: pos_y, z: pos_z};

	always_comb begin
		q_job.corner[0] = hold_q[0];
		q_job.corner[1] = hold_q[1];
		q_job.corner[2] = cur;
		q_job.has_tri   = (held_q == 2'd2);
		q_job.is_end    = end_of_mesh;
	end

	// push on the third corner, or on an end mark that drops a partial triangle
	assign q_push = acc && ((held_q == 2'd2) || end_of_mesh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
		end else if (acc) begin
			if ((held_q == 2'd2) || end_of_mesh) begin
				held_q <= 2'd0;
			end else begin
				held_q <= held_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && held_q != 2'd2 && !end_of_mesh) begin
			hold_q[held_q[0]] <= cur;
		end
	end

endmodule

// File: rtl/gmb_fifo.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front and back ends.
// Depends on gmb_pkg.
module gmb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gmb_pkg::job_t push_job,
	input  logic          pop,
	output gmb_pkg::job_t pop_job,
	output logic          full,
	output logic          avail
);
	import gmb_pkg::*;

	job_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// File: rtl/gmb_cdiv.sv
`timescale 1ns / 1ps
// Centroid divider: three restoring lanes, one quotient bit per cycle.
// Depends on gmb_pkg.
module gmb_cdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [gmb_pkg::SUM_W-1:0]  sum [3],
	input  logic [gmb_pkg::CNT_W-1:0]         divisor,
	output logic                              done,
	output logic signed [gmb_pkg::CRD_W-1:0]  quot [3]
);
	import gmb_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  mag_q [3];
	logic [CNT_W-1:0]  rem_q [3];
	logic              neg_q [3];
	logic [CNT_W:0]    trial [3];
	logic              bit_ok [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k]  = {rem_q[k], mag_q[k][SUM_W-1]};
			bit_ok[k] = (trial[k] >= {1'b0, divisor});
			quot[k]   = neg_q[k] ? -$signed(mag_q[k][CRD_W-1:0]) : $signed(mag_q[k][CRD_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (start) begin
				neg_q[k] <= sum[k][SUM_W-1];
				mag_q[k] <= sum[k][SUM_W-1] ? SUM_W'(-sum[k]) : SUM_W'(sum[k]);
				rem_q[k] <= '0;
			end else if (busy_q) begin
				rem_q[k] <= bit_ok[k] ? CNT_W'(trial[k] - {1'b0, divisor}) : trial[k][CNT_W-1:0];
				mag_q[k] <= {mag_q[k][SUM_W-2:0], bit_ok[k]};
			end
		end
	end

endmodule

// File: rtl/gmb_isqrt.sv
`timescale 1ns / 1ps
// Floor square root, one result bit per cycle.
// Depends on gmb_pkg.
module gmb_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gmb_pkg::SQ_W-1:0]    value,
	output logic                        done,
	output logic [gmb_pkg::ROOT_W-1:0]  root
);
	import gmb_pkg::*;

	localparam int STEPS  = SQ_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SQ_W-1:0]   op_q, res_q, one_q, trial;
	logic              fits;

	assign trial = res_q + one_q;
	assign fits  = (op_q >= trial);
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(STEPS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= value;
			res_q <= '0;
			one_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			op_q  <= fits ? op_q - trial : op_q;
			res_q <= fits ? (res_q >> 1) + one_q : res_q >> 1;
			one_q <= one_q >> 2;
		end
	end

endmodule

// File: rtl/gmb_back.sv
`timescale 1ns / 1ps
// Back end: member lookup, meshlet close with bounding sphere, insertion and
// record output. Depends on gmb_pkg, gmb_cdiv and gmb_isqrt.
module gmb_back #(
	parameter int MAX_VERTS = 64,
	parameter int MAX_TRIS  = 124
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gmb_pkg::CNT_W-1:0]      cfg_data,
	input  logic                           job_avail,
	input  gmb_pkg::job_t                  job,
	output logic                           job_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output gmb_pkg::rec_t                  rec
);
	import gmb_pkg::*;

	localparam int VIDX_W = $clog2(MAX_VERTS);
	localparam logic [CNT_W-1:0] VL_CEIL = CNT_W'(MAX_VERTS);
	localparam logic [CNT_W-1:0] TL_CEIL = CNT_W'(MAX_TRIS);

	typedef enum logic [3:0] {
		S_IDLE, S_LK_RD, S_LK_CMP, S_DECIDE, S_DIV, S_DIV_WAIT,
		S_R_RD, S_R_DIFF, S_R_SQ, S_R_ACC, S_SQRT, S_SQRT_WAIT,
		S_DESC, S_INS, S_TRI
	} state_t;

	state_t                  state_q;
	job_t                    job_q;
	logic [CNT_W-1:0]        vl_q, tl_q, vl_eff, tl_eff;
	logic [2:0]              found_q;
	logic [VIDX_W-1:0]       idx_q [3];
	logic [VIDX_W-1:0]       local_q [3];
	logic [CNT_W-1:0]        scan_q, member_cnt_q, tri_cnt_q;
	logic [1:0]              k_q;
	logic                    close_end_q;
	logic [31:0]             base_v_q, base_t_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [CRD_W-1:0] centre_q [3];
	logic [ROOT_W-1:0]       radius_q;
	logic [SQ_W-1:0]         best_q;
	logic [CRD_W-1:0]        dmag_s1 [3];
	logic [2*CRD_W-1:0]      sq_s2 [3];

	logic [TAG_W-1:0]        tag_mem [MAX_VERTS];
	logic [3*CRD_W-1:0]      crd_mem [MAX_VERTS];
	logic [TAG_W-1:0]        tag_rd_q;
	logic [3*CRD_W-1:0]      crd_rd_q;

	logic                    emit_ok, need_close, need_add, dup0, dup1, mem_we;
	logic [1:0]              fresh;
	corner_t                 cur;
	logic [SQ_W-1:0]         sq_dist;
	logic                    div_start, div_done, sq_start, sq_done;
	logic signed [CRD_W-1:0] quot [3];
	logic [ROOT_W-1:0]       root;
	logic                    fire;
	rec_t                    rec_nxt;

	// limits in use, clamped to what the stores can hold
	always_comb begin
		vl_eff = (vl_q < VL_FLOOR) ? VL_FLOOR : ((vl_q > VL_CEIL) ? VL_CEIL : vl_q);
		tl_eff = (tl_q < TL_FLOOR) ? TL_FLOOR : ((tl_q > TL_CEIL) ? TL_CEIL : tl_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q <= VL_RESET;
			tl_q <= TL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VERTEX_LIMIT:   vl_q <= cfg_data;
				CFG_TRIANGLE_LIMIT: tl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign emit_ok   = !out_valid || !out_stall;
	assign job_pop   = (state_q == S_IDLE) && job_avail;
	assign fresh     = 2'(!found_q[0]) + 2'(!found_q[1]) + 2'(!found_q[2]);
	assign need_close = ({1'b0, member_cnt_q} + (CNT_W+1)'(fresh) > {1'b0, vl_eff}) ||
	                    ({1'b0, tri_cnt_q} + 1'b1 > {1'b0, tl_eff});
	assign cur       = job_q.corner[k_q];
	assign dup0      = (k_q != 2'd0) && (job_q.corner[0].tag == cur.tag);
	assign dup1      = (k_q == 2'd2) && (job_q.corner[1].tag == cur.tag);
	assign need_add  = !found_q[k_q] && !dup0 && !dup1;
	assign mem_we    = (state_q == S_INS) && need_add && emit_ok;
	assign div_start = (state_q == S_DIV);
	assign sq_start  = (state_q == S_SQRT);
	assign sq_dist   = SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);

	// next record and the cycle it is loaded into the output register
	always_comb begin
		rec_nxt = '0;
		fire    = 1'b0;
		case (state_q)
			S_DESC: begin
				fire              = emit_ok;
				rec_nxt.kind      = KIND_DESC;
				rec_nxt.word_a    = base_v_q;
				rec_nxt.word_b    = base_t_q;
				rec_nxt.word_c    = member_cnt_q;
				rec_nxt.tri_total = tri_cnt_q;
				rec_nxt.cx        = centre_q[0];
				rec_nxt.cy        = centre_q[1];
				rec_nxt.cz        = centre_q[2];
				rec_nxt.radius    = radius_q;
				rec_nxt.last      = close_end_q;
			end
			S_INS: begin
				fire           = need_add && emit_ok;
				rec_nxt.kind   = KIND_VERTEX;
				rec_nxt.word_a = cur.tag;
			end
			S_TRI: begin
				fire           = emit_ok;
				rec_nxt.kind   = KIND_TRI;
				rec_nxt.word_a = 32'(local_q[0]);
				rec_nxt.word_b = 32'(local_q[1]);
				rec_nxt.word_c = CNT_W'(local_q[2]);
				rec_nxt.last   = !job_q.is_end;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rec <= rec_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[member_cnt_q[VIDX_W-1:0]] <= cur.tag;
			crd_mem[member_cnt_q[VIDX_W-1:0]] <= {cur.z, cur.y, cur.x};
		end
		tag_rd_q <= tag_mem[scan_q[VIDX_W-1:0]];
		crd_rd_q <= crd_mem[scan_q[VIDX_W-1:0]];
	end

	gmb_cdiv u_cdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sum     (sum_q),
		.divisor (member_cnt_q),
		.done    (div_done),
		.quot    (quot)
	);

	gmb_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (best_q),
		.done   (sq_done),
		.root   (root)
	);

	// datapath stages of the radius walk
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			logic signed [CRD_W:0] d;
			d = (CRD_W+1)'($signed(crd_rd_q[k*CRD_W +: CRD_W])) - (CRD_W+1)'(centre_q[k]);
			if (state_q == S_R_DIFF) begin
				dmag_s1[k] <= d[CRD_W] ? CRD_W'(-d) : d[CRD_W-1:0];
			end
			if (state_q == S_R_SQ) begin
				sq_s2[k] <= dmag_s1[k] * dmag_s1[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			found_q      <= '0;
			scan_q       <= '0;
			k_q          <= '0;
			close_end_q  <= 1'b0;
			member_cnt_q <= '0;
			tri_cnt_q    <= '0;
			base_v_q     <= '0;
			base_t_q     <= '0;
			sum_q        <= '{default: '0};
			out_valid    <= 1'b0;
		end else begin
			// hold a stalled record, load a new one when it fires
			out_valid <= fire || (out_valid && out_stall);
			case (state_q)
				S_IDLE: begin
					if (job_avail) begin
						job_q   <= job;
						found_q <= '0;
						scan_q  <= '0;
						if (job.has_tri) begin
							state_q <= S_LK_RD;
						end else if (tri_cnt_q != '0) begin
							close_end_q <= 1'b1;
							state_q     <= S_DIV;
						end else begin
							member_cnt_q <= '0;
							sum_q        <= '{default: '0};
							base_v_q     <= '0;
							base_t_q     <= '0;
						end
					end
				end
				S_LK_RD: begin
					state_q <= (scan_q == member_cnt_q) ? S_DECIDE : S_LK_CMP;
				end
				S_LK_CMP: begin
					for (int k = 0; k < 3; k++) begin
						if (!found_q[k] && tag_rd_q == job_q.corner[k].tag) begin
							found_q[k] <= 1'b1;
							idx_q[k]   <= scan_q[VIDX_W-1:0];
						end
					end
					scan_q  <= scan_q + 1'b1;
					state_q <= S_LK_RD;
				end
				S_DECIDE: begin
					k_q <= '0;
					if (need_close) begin
						found_q     <= '0;
						close_end_q <= 1'b0;
						state_q     <= S_DIV;
					end else begin
						state_q <= S_INS;
					end
				end
				S_DIV: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						centre_q <= quot;
						scan_q   <= '0;
						best_q   <= '0;
						state_q  <= S_R_RD;
					end
				end
				S_R_RD: begin
					state_q <= (scan_q == member_cnt_q) ? S_SQRT : S_R_DIFF;
				end
				S_R_DIFF: state_q <= S_R_SQ;
				S_R_SQ:   state_q <= S_R_ACC;
				S_R_ACC: begin
					if (sq_dist > best_q) begin
						best_q <= sq_dist;
					end
					scan_q  <= scan_q + 1'b1;
					state_q <= S_R_RD;
				end
				S_SQRT: begin
					state_q <= S_SQRT_WAIT;
				end
				S_SQRT_WAIT: begin
					if (sq_done) begin
						radius_q <= root;
						state_q  <= S_DESC;
					end
				end
				S_DESC: begin
					if (emit_ok) begin
						member_cnt_q  <= '0;
						tri_cnt_q     <= '0;
						sum_q         <= '{default: '0};
						if (close_end_q) begin
							base_v_q <= '0;
							base_t_q <= '0;
							state_q  <= S_IDLE;
						end else begin
							base_v_q <= base_v_q + 32'(member_cnt_q);
							base_t_q <= base_t_q + 32'({tri_cnt_q, 1'b0}) + 32'(tri_cnt_q);
							state_q  <= S_INS;
						end
					end
				end
				S_INS: begin
					if (found_q[k_q]) begin
						local_q[k_q] <= idx_q[k_q];
					end else if (dup0) begin
						local_q[k_q] <= local_q[0];
					end else if (dup1) begin
						local_q[k_q] <= local_q[1];
					end
					if (!need_add || emit_ok) begin
						if (need_add) begin
							local_q[k_q]  <= member_cnt_q[VIDX_W-1:0];
							member_cnt_q  <= member_cnt_q + 1'b1;
							sum_q[0]      <= sum_q[0] + SUM_W'(cur.x);
							sum_q[1]      <= sum_q[1] + SUM_W'(cur.y);
							sum_q[2]      <= sum_q[2] + SUM_W'(cur.z);
						end
						k_q     <= k_q + 2'd1;
						state_q <= (k_q == 2'd2) ? S_TRI : S_INS;
					end
				end
				S_TRI: begin
					if (emit_ok) begin
						tri_cnt_q  <= tri_cnt_q + 1'b1;
						if (job_q.is_end) begin
							close_end_q <= 1'b1;
							state_q     <= S_DIV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/greedy_meshlet_builder_unit.sv
`timescale 1ns / 1ps
// Greedy meshlet builder. A corner is taken each cycle while the two-entry job queue has room.
// For each triangle the tag store is walked once over the M members held.
// A meshlet close runs a centroid divide, then a walk over the position store that reads,
// differences, squares and accumulates each member in turn, and then a square root.
// Reset clears all counts and offsets, including the count of held corners; limits return to 64 and 124.
// Depends on gmb_pkg, gmb_front, gmb_fifo and gmb_back.
module greedy_meshlet_builder_unit #(
	parameter int MAX_VERTS = 64,
	parameter int MAX_TRIS  = 124
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gmb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmb_pkg::CNT_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     vertex_index,
	input  logic signed [31:0]              pos_x,
	input  logic signed [31:0]              pos_y,
	input  logic signed [31:0]              pos_z,
	input  logic                            end_of_mesh,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      record_kind,
	output logic [31:0]                     word_a,
	output logic [31:0]                     word_b,
	output logic [8:0]                      word_c,
	output logic [8:0]                      tri_total,
	output logic signed [31:0]              centre_x,
	output logic signed [31:0]              centre_y,
	output logic signed [31:0]              centre_z,
	output logic [32:0]                     sphere_radius,
	output logic                            last
);
	import gmb_pkg::*;

	job_t push_job, pop_job;
	logic push, pop, full, avail;
	rec_t rec;

	// front: gather three corners per triangle, classify flush requests
	gmb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.end_of_mesh  (end_of_mesh),
		.q_full       (full),
		.q_push       (push),
		.q_job        (push_job)
	);

	// queue: decouple corner intake from the slow meshlet work
	gmb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (full),
		.avail    (avail)
	);

	// back: lookup, close with bounding sphere, insert and emit each request's records
	gmb_back #(
		.MAX_VERTS (MAX_VERTS),
		.MAX_TRIS  (MAX_TRIS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_avail (avail),
		.job       (pop_job),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rec       (rec)
	);

	// unpack the output register onto the ports
	assign record_kind   = rec.kind;
	assign word_a        = rec.word_a;
	assign word_b        = rec.word_b;
	assign word_c        = rec.word_c;
	assign tri_total     = rec.tri_total;
	assign centre_x      = rec.cx;
	assign centre_y      = rec.cy;
	assign centre_z      = rec.cz;
	assign sphere_radius = rec.radius;
	assign last          = rec.last;

endmodule

// File: rtl/gmb_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the meshlet builder.
// Depends on gmb_pkg; bound to greedy_meshlet_builder_unit.
module gmb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         record_kind,
	input logic [31:0]        word_b,
	input logic [8:0]         word_c,
	input logic [8:0]         tri_total,
	input logic signed [31:0] centre_x,
	input logic [32:0]        sphere_radius
);
	import gmb_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_vertex_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_VERTEX |->
		word_b == '0 && word_c == '0 && tri_total == '0 && sphere_radius == '0)
		else $error("vertex entry carries stray fields");

	a_tri_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_TRI |->
		tri_total == '0 && centre_x == '0 && sphere_radius == '0)
		else $error("triangle record carries stray fields");

	a_desc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_DESC |-> word_c != '0 && tri_total != '0)
		else $error("empty meshlet descriptor");

endmodule

bind greedy_meshlet_builder_unit gmb_checker u_gmb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.record_kind   (record_kind),
	.word_b        (word_b),
	.word_c        (word_c),
	.tri_total     (tri_total),
	.centre_x      (centre_x),
	.sphere_radius (sphere_radius)
);
